// File: rtl/contiguous_block_allocator_defines.svh
// Assertion macros for the contiguous block allocator.
// Included by the RTL modules that carry assertions; no other dependencies.
`ifndef CONTIGUOUS_BLOCK_ALLOCATOR_DEFINES_SVH
`define CONTIGUOUS_BLOCK_ALLOCATOR_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define CBA_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("contiguous_block_allocator assertion failed");
`define CBA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("contiguous_block_allocator assertion failed");
`else
`define CBA_ASSERT_NOW(label, clk, rst, ante, cons)
`define CBA_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// File: rtl/cba_pkg.sv
// Shared constants, types and enums for the contiguous block allocator.
// No dependencies.
`default_nettype none
package cba_pkg;
   localparam int MAX_BLOCKS  = 1024;
   localparam int BLOCK_BYTES = 64;
   // block size must be a power of two
   localparam int BLOCK_SHIFT = $clog2(BLOCK_BYTES);
   localparam int WORD_BITS   = 8;
   localparam int CELLS       = MAX_BLOCKS / WORD_BITS;
   localparam int CELL_W      = $clog2(CELLS);
   localparam int SUB_W       = $clog2(WORD_BITS);
   localparam int IDX_W       = CELL_W + SUB_W;
   localparam int POS_W       = $clog2(MAX_BLOCKS + 1);
   localparam int LEN_W       = 16;
   localparam int START_W     = 10;
   localparam int RUN_W       = 10;
   localparam int CFG_W       = 11;
   localparam int NEED_MAX    = ((1 << LEN_W) - 1 + BLOCK_BYTES - 1) / BLOCK_BYTES;
   localparam int NEED_W      = $clog2(NEED_MAX + 1);
   localparam int SUM_W       = $clog2(MAX_BLOCKS + NEED_MAX + 1);
   localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(1024);

   typedef enum logic {
      OP_ALLOC = 1'b0,
      OP_FREE  = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_MARK,
      ST_DONE
   } state_type;

   typedef struct packed {
      op_type             operation;
      logic [START_W-1:0] start_block;
      logic [LEN_W-1:0]   length_bytes;
   } req_word_type;

   typedef struct packed {
      logic             success;
      logic [RUN_W-1:0] run_start;
   } rsp_word_type;

   typedef struct packed {
      logic                 shift;
      logic [WORD_BITS-1:0] word;
   } ring_feed_type;
endpackage
`default_nettype wire

// File: rtl/cba_cell.sv
// One cell of the used-map ring: holds one word of block flags.
// Depends on cba_pkg.
`default_nettype none
module cba_cell (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          shift,
   input  wire logic [cba_pkg::WORD_BITS-1:0] din,
   output logic      [cba_pkg::WORD_BITS-1:0] dout
);
   logic [cba_pkg::WORD_BITS-1:0] word_ff;
   logic [cba_pkg::WORD_BITS-1:0] word_in;

   assign word_in = shift ? din : word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         word_ff <= '0;
      end else begin
         word_ff <= word_in;
      end
   end

   assign dout = word_ff;
endmodule
`default_nettype wire

// File: rtl/cba_ctrl.sv
// Sequencer for the allocator: first-fit scan and mark passes over the ring head.
// Depends on cba_pkg and contiguous_block_allocator_defines.svh.
`default_nettype none
`include "contiguous_block_allocator_defines.svh"
module cba_ctrl (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire cba_pkg::req_word_type         req_word,
   input  wire logic [cba_pkg::CFG_W-1:0]     total_blocks,
   input  wire logic [cba_pkg::WORD_BITS-1:0] head_word,
   output cba_pkg::ring_feed_type             feed,
   output logic                               rsp_valid,
   output cba_pkg::rsp_word_type              rsp_word
);
   cba_pkg::state_type              state_ff, state_in;
   cba_pkg::op_type                 op_ff, op_in;
   logic [cba_pkg::NEED_W-1:0]      need_ff, need_in;
   logic [cba_pkg::POS_W-1:0]       start_ff, start_in;
   logic [cba_pkg::NEED_W-1:0]      run_ff, run_in;
   logic [cba_pkg::CELL_W-1:0]      widx_ff, widx_in;
   logic                            success_ff, success_in;
   logic [cba_pkg::RUN_W-1:0]       run_start_ff, run_start_in;

   logic                            accept;
   logic [cba_pkg::LEN_W:0]         len_sum;
   logic [cba_pkg::NEED_W-1:0]      need_req;
   logic [cba_pkg::POS_W-1:0]       lim;
   logic [cba_pkg::POS_W-1:0]       pos;
   logic [cba_pkg::NEED_W-1:0]      scan_run;
   logic [cba_pkg::POS_W-1:0]       scan_start;
   logic [cba_pkg::SUM_W-1:0]       hi;
   logic [cba_pkg::SUM_W-1:0]       lo;
   logic [cba_pkg::SUM_W-1:0]       mpos;
   logic [cba_pkg::WORD_BITS-1:0]   mark_word;
   logic                            last_word;

   assign accept    = start && (state_ff == cba_pkg::ST_IDLE);
   assign busy      = (state_ff != cba_pkg::ST_IDLE);
   assign len_sum   = {1'b0, req_word.length_bytes} +
                      (cba_pkg::LEN_W + 1)'(cba_pkg::BLOCK_BYTES - 1);
   assign need_req  = cba_pkg::NEED_W'(len_sum >> cba_pkg::BLOCK_SHIFT);
   assign lim       = (total_blocks > cba_pkg::CFG_W'(cba_pkg::MAX_BLOCKS)) ?
                      cba_pkg::POS_W'(cba_pkg::MAX_BLOCKS) :
                      cba_pkg::POS_W'(total_blocks);
   assign last_word = (widx_ff == cba_pkg::CELL_W'(cba_pkg::CELLS - 1));
   assign lo        = cba_pkg::SUM_W'(start_ff);
   assign hi        = cba_pkg::SUM_W'(start_ff) + cba_pkg::SUM_W'(need_ff);

   // first-fit step over one word
   always_comb begin
      scan_run   = run_ff;
      scan_start = start_ff;
      pos        = '0;
      for (int j = 0; j < cba_pkg::WORD_BITS; j++) begin
         pos = cba_pkg::POS_W'({widx_ff, cba_pkg::SUB_W'(j)});
         if ((pos < lim) && (scan_run < need_ff)) begin
            if (!head_word[j]) begin
               scan_run = scan_run + 1'b1;
            end else begin
               scan_run   = '0;
               scan_start = pos + 1'b1;
            end
         end
      end
   end

   // set or clear the flags of the run inside this word
   always_comb begin
      mpos = '0;
      for (int j = 0; j < cba_pkg::WORD_BITS; j++) begin
         mpos = cba_pkg::SUM_W'({widx_ff, cba_pkg::SUB_W'(j)});
         if ((mpos >= lo) && (mpos < hi)) begin
            mark_word[j] = (op_ff == cba_pkg::OP_ALLOC);
         end else begin
            mark_word[j] = head_word[j];
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      need_in      = need_ff;
      start_in     = start_ff;
      run_in       = run_ff;
      widx_in      = widx_ff;
      success_in   = success_ff;
      run_start_in = run_start_ff;
      feed.shift   = 1'b0;
      feed.word    = head_word;
      case (state_ff)
         cba_pkg::ST_IDLE: begin
            if (accept) begin
               op_in    = req_word.operation;
               need_in  = need_req;
               start_in = (req_word.operation == cba_pkg::OP_FREE) ?
                          cba_pkg::POS_W'(req_word.start_block) : '0;
               run_in   = '0;
               widx_in  = '0;
               state_in = (req_word.operation == cba_pkg::OP_ALLOC) ?
                          cba_pkg::ST_SCAN : cba_pkg::ST_MARK;
            end
         end
         cba_pkg::ST_SCAN: begin
            feed.shift = 1'b1;
            run_in     = scan_run;
            start_in   = scan_start;
            widx_in    = widx_ff + 1'b1;
            if (last_word) begin
               if (scan_run == need_ff) begin
                  state_in = cba_pkg::ST_MARK;
               end else begin
                  success_in   = 1'b0;
                  run_start_in = '0;
                  state_in     = cba_pkg::ST_DONE;
               end
            end
         end
         cba_pkg::ST_MARK: begin
            feed.shift = 1'b1;
            feed.word  = mark_word;
            widx_in    = widx_ff + 1'b1;
            if (last_word) begin
               success_in   = 1'b1;
               run_start_in = (op_ff == cba_pkg::OP_ALLOC) ?
                              cba_pkg::RUN_W'(start_ff) : '0;
               state_in     = cba_pkg::ST_DONE;
            end
         end
         cba_pkg::ST_DONE: begin
            state_in = cba_pkg::ST_IDLE;
         end
         default: begin
            state_in = cba_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cba_pkg::ST_IDLE;
         widx_ff  <= '0;
      end else begin
         state_ff <= state_in;
         widx_ff  <= widx_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      need_ff      <= need_in;
      start_ff     <= start_in;
      run_ff       <= run_in;
      success_ff   <= success_in;
      run_start_ff <= run_start_in;
   end

   assign rsp_valid          = (state_ff == cba_pkg::ST_DONE);
   assign rsp_word.success   = success_ff;
   assign rsp_word.run_start = run_start_ff;

   `CBA_ASSERT_NEXT(a_accept_busy, clock, reset, accept, busy)
   `CBA_ASSERT_NEXT(a_strobe_single, clock, reset, rsp_valid, !rsp_valid)
   `CBA_ASSERT_NOW(a_fail_zero, clock, reset, rsp_valid && !rsp_word.success,
      rsp_word.run_start == '0)
   `CBA_ASSERT_NOW(a_free_ok, clock, reset, rsp_valid && (op_ff == cba_pkg::OP_FREE),
      rsp_word.success && (rsp_word.run_start == '0))
   `CBA_ASSERT_NOW(a_idle_aligned, clock, reset, state_ff == cba_pkg::ST_IDLE,
      widx_ff == '0)
endmodule
`default_nettype wire

// File: rtl/contiguous_block_allocator.sv
// Top level of the first-fit contiguous block allocator.
// Depends on cba_pkg, cba_cell and cba_ctrl.
//
// Usage:
//  - Request: drive req_word and raise start; the word is taken at a rising
//    edge where start is high and busy is low. busy stays high until the
//    response has been shown.
//  - Response: rsp_valid is high for exactly one cycle with rsp_word; the
//    receiver cannot stall, so it must take the word in that cycle.
//  - The used map sits in a ring of 128 cells of 8 blocks each; the ring
//    advances one cell per cycle during a scan or mark pass and the head
//    cell passes through the sequencer, which handles 8 blocks per cycle.
//  - From accept to rsp_valid: allocate that fails runs a scan lap,
//    allocate that succeeds a scan lap then a mark lap, free a mark lap
//    only. Next request can be taken in the cycle after the response.
//  - Config: csr_data (total_blocks) is written when csr_valid and csr_ready
//    are high; csr_ready is high while the block is idle.
//  - Reset: all blocks free, total_blocks = 1024, no response pending.
`default_nettype none
module contiguous_block_allocator (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   output logic                           busy,
   input  wire cba_pkg::req_word_type     req_word,
   output logic                           rsp_valid,
   output cba_pkg::rsp_word_type          rsp_word,
   input  wire logic                      csr_valid,
   output logic                           csr_ready,
   input  wire logic [cba_pkg::CFG_W-1:0] csr_data
);
   logic [cba_pkg::CFG_W-1:0]     total_blocks_ff;
   logic [cba_pkg::CFG_W-1:0]     total_blocks_in;
   logic [cba_pkg::WORD_BITS-1:0] cell_out [cba_pkg::CELLS];
   cba_pkg::ring_feed_type        feed;

   assign csr_ready       = !busy;
   assign total_blocks_in = (csr_valid && csr_ready) ? csr_data : total_blocks_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         total_blocks_ff <= cba_pkg::CFG_RESET;
      end else begin
         total_blocks_ff <= total_blocks_in;
      end
   end

   for (genvar i = 0; i < cba_pkg::CELLS; i++) begin : g_ring
      if (i == cba_pkg::CELLS - 1) begin : g_tail
         cba_cell u_cell (
            .clock (clock),
            .reset (reset),
            .shift (feed.shift),
            .din   (feed.word),
            .dout  (cell_out[i])
         );
      end else begin : g_body
         cba_cell u_cell (
            .clock (clock),
            .reset (reset),
            .shift (feed.shift),
            .din   (cell_out[i+1]),
            .dout  (cell_out[i])
         );
      end
   end

   cba_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_word     (req_word),
      .total_blocks (total_blocks_ff),
      .head_word    (cell_out[0]),
      .feed         (feed),
      .rsp_valid    (rsp_valid),
      .rsp_word     (rsp_word)
   );
endmodule
`default_nettype wire

// File: tb/sv/cba_tb_pkg.sv
// Block map scoreboard for the contiguous block allocator testbench: mirrors the
// used map and the block count register, predicts each response and checks it.
// Depends on cba_pkg.
`timescale 1ns / 100ps
package cba_tb_pkg;
   import cba_pkg::*;

   class block_map_scoreboard;
      bit           used_blocks[MAX_BLOCKS];
      int           total_blocks;
      rsp_word_type awaited_replies[$];
      int           mismatches;

      function new();
         foreach (used_blocks[i]) used_blocks[i] = 1'b0;
         total_blocks = int'(CFG_RESET);
         mismatches   = 0;
      endfunction

      function void set_total_blocks(logic [CFG_W-1:0] value);
         total_blocks = int'(value);
      endfunction

      function int outstanding();
         return awaited_replies.size();
      endfunction

      function rsp_word_type note_request(req_word_type w);
         int           need;
         int           scan_end;
         int           pos;
         int           run;
         int           first;
         int           b;
         rsp_word_type reply;
         need  = (int'(w.length_bytes) + BLOCK_BYTES - 1) / BLOCK_BYTES;
         reply = '0;
         if (w.operation == OP_ALLOC) begin
            scan_end = (total_blocks < MAX_BLOCKS) ? total_blocks : MAX_BLOCKS;
            pos      = 0;
            run      = 0;
            first    = 0;
            while (pos < scan_end && run < need) begin
               if (used_blocks[pos]) begin
                  run   = 0;
                  first = pos + 1;
               end else begin
                  run++;
               end
               pos++;
            end
            if (run == need) begin
               for (b = first; b < first + need && b < MAX_BLOCKS; b++)
                  used_blocks[b] = 1'b1;
               reply.success   = 1'b1;
               reply.run_start = RUN_W'(first);
            end
         end else begin
            for (b = int'(w.start_block); b < int'(w.start_block) + need && b < MAX_BLOCKS; b++)
               used_blocks[b] = 1'b0;
            reply.success = 1'b1;
         end
         awaited_replies.push_back(reply);
         return reply;
      endfunction

      function void report(string field, int want, int got);
         mismatches++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      endfunction

      function void check_response(rsp_word_type got);
         rsp_word_type want;
         if (awaited_replies.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected response, expected none, actual %0h", $time, got);
            return;
         end
         want = awaited_replies.pop_front();
         if (got.success !== want.success)
            report("success", want.success, got.success);
         if (got.run_start !== want.run_start)
            report("run_start", want.run_start, got.run_start);
      endfunction
   endclass
endpackage

// File: tb/sv/testbench.sv
// Top-level testbench for the contiguous block allocator: drives allocate and
// free words and block count writes, and checks every response on the fly.
// Depends on cba_pkg, cba_tb_pkg and the allocator RTL.
`timescale 1ns / 100ps
module testbench;
   import cba_pkg::*;
   import cba_tb_pkg::*;

   localparam int CYCLE_LIMIT   = 4_000_000;
   localparam int SETTLE_CYCLES = 300;
   localparam int PHASES        = 9;
   localparam int PHASE_TOTAL[PHASES] = '{1024, 2047, 0, 1, 1023, 1025, -1, 40, 1024};
   localparam int PHASE_ITEMS[PHASES] = '{300, 250, 60, 60, 280, 200, 250, 250, 280};

   logic                clock     = 1'b0;
   logic                reset     = 1'b1;
   logic                start     = 1'b0;
   logic                busy;
   req_word_type        req_word  = '0;
   logic                rsp_valid;
   rsp_word_type        rsp_word;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [CFG_W-1:0]    csr_data  = '0;

   block_map_scoreboard sb;
   req_word_type        live_runs[$];
   int                  gap_pct     = 35;
   int                  cycle_count = 0;

   contiguous_block_allocator dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid)
         sb.check_response(rsp_word);
   end

   function automatic req_word_type make_word(op_type op, int first, logic [LEN_W-1:0] len);
      req_word_type w;
      w.operation    = op;
      w.start_block  = START_W'(first);
      w.length_bytes = len;
      return w;
   endfunction

   function automatic logic [LEN_W-1:0] bytes_for(int blocks);
      if (blocks == 0)
         return '0;
      return LEN_W'((blocks - 1) * BLOCK_BYTES + $urandom_range(1, BLOCK_BYTES));
   endfunction

   // drop start and hold until every response has been shown
   task automatic drain();
      start <= 1'b0;
      do @(posedge clock); while (sb.outstanding() != 0);
   endtask

   task automatic write_total(logic [CFG_W-1:0] value);
      drain();
      csr_data  <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      sb.set_total_blocks(value);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic sender_pause();
      if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
         if ($urandom_range(0, 1) == 1)
            drain();
         else
            start <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
   endtask

   task automatic issue(req_word_type w);
      rsp_word_type want;
      sender_pause();
      req_word <= w;
      start    <= 1'b1;
      do @(posedge clock); while (busy);
      want = sb.note_request(w);
      if (w.operation == OP_ALLOC && want.success && w.length_bytes != 0)
         live_runs.push_back(make_word(OP_FREE, int'(want.run_start), w.length_bytes));
   endtask

   task automatic random_item();
      int           pick;
      int           k;
      req_word_type w;
      pick = $urandom_range(0, 99);
      if (pick >= 55 && pick < 85 && live_runs.size() == 0)
         pick = 0;
      w = make_word(OP_ALLOC, $urandom_range(0, 1023), bytes_for($urandom_range(1, 16)));
      if (pick < 45) begin
      end else if (pick < 50) begin
         w.length_bytes = bytes_for($urandom_range(17, 1024));
      end else if (pick < 53) begin
         w.length_bytes = '0;
      end else if (pick < 55) begin
         w.length_bytes = LEN_W'($urandom);
      end else if (pick < 85) begin
         k = $urandom_range(0, live_runs.size() - 1);
         w = live_runs[k];
         live_runs.delete(k);
      end else if (pick < 97) begin
         w.operation = OP_FREE;
         if ($urandom_range(0, 3) == 0)
            w.length_bytes = LEN_W'($urandom);
      end else begin
         w = make_word(OP_FREE, 0, 16'hFFFF);
         live_runs.delete();
      end
      issue(w);
   endtask

   initial begin
      int p;
      int value;
      sb = new();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      write_total(CFG_W'(1024));
      issue(make_word(OP_ALLOC, 0, 16'd0));
      issue(make_word(OP_ALLOC, 0, 16'd1));
      issue(make_word(OP_ALLOC, 0, 16'd64));
      issue(make_word(OP_ALLOC, 0, 16'd65));
      issue(make_word(OP_ALLOC, 0, 16'hFFFF));
      issue(make_word(OP_FREE, 1, 16'd64));
      issue(make_word(OP_ALLOC, 0, 16'd64));
      issue(make_word(OP_ALLOC, 0, 16'd65280));
      issue(make_word(OP_ALLOC, 0, 16'd1));
      issue(make_word(OP_FREE, 1023, 16'hFFFF));
      issue(make_word(OP_ALLOC, 0, 16'd1));
      issue(make_word(OP_FREE, 0, 16'hFFFF));
      issue(make_word(OP_ALLOC, 0, 16'hFFFF));
      issue(make_word(OP_FREE, 0, 16'hFFFF));
      write_total(CFG_W'(0));
      issue(make_word(OP_ALLOC, 0, 16'd1));
      issue(make_word(OP_ALLOC, 0, 16'd0));
      write_total(CFG_W'(1));
      issue(make_word(OP_ALLOC, 0, 16'd64));
      issue(make_word(OP_ALLOC, 0, 16'd1));
      issue(make_word(OP_FREE, 0, 16'd1));
      write_total(CFG_W'(2047));
      issue(make_word(OP_ALLOC, 0, 16'hFFFF));
      issue(make_word(OP_FREE, 1023, 16'hFFFF));
      issue(make_word(OP_FREE, 0, 16'hFFFF));
      issue(make_word(OP_ALLOC, 1023, 16'd128));
      issue(make_word(OP_FREE, 5, 16'd0));
      live_runs.delete();

      for (p = 0; p < PHASES; p++) begin
         value   = (PHASE_TOTAL[p] < 0) ? $urandom_range(2, 1022) : PHASE_TOTAL[p];
         gap_pct = (p == PHASES - 1 || p % 2 == 1) ? 0 : 35;
         write_total(CFG_W'(value));
         repeat (PHASE_ITEMS[p]) random_item();
      end

      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.mismatches == 0 && sb.outstanding() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end
endmodule
